FILE: hdl/gss_pkg.sv
`timescale 1ns / 1ps
// shared types, register map and constants of the gear shift sequencer
package gss_pkg;

  // field widths
  localparam int unsigned PosW    = 12;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ClutchW = 12;
  localparam int unsigned GearW   = 3;
  localparam int unsigned TickW   = 16;
  localparam int unsigned NumGears = 6;

  // configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 3;

  // valve hold time in ticks
  localparam logic [TickW-1:0] HOLD_TICKS = 16'd100;

  // largest possible level distance, start value of the nearest search
  localparam logic [PosW-1:0] MAX_DIST = 12'd4095;

  // register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_LEVEL_0     = 3'd0,
    REG_LEVEL_1     = 3'd1,
    REG_LEVEL_2     = 3'd2,
    REG_LEVEL_3     = 3'd3,
    REG_LEVEL_4     = 3'd4,
    REG_LEVEL_5     = 3'd5,
    REG_SPEED_THR   = 3'd6,
    REG_CUTOFF_TCKS = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [PosW-1:0] LEVEL_RST [NumGears] =
    '{12'd3260, 12'd3620, 12'd200, 12'd875, 12'd1570, 12'd2250};
  localparam logic [SpeedW-1:0] SPEED_THR_RST  = 16'd11000;
  localparam logic [TickW-1:0]  CUTOFF_TCK_RST = 16'd30;

  // sequencer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CUT  = 3'b010,
    PH_HOLD = 3'b100
  } phase_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [NumGears-1:0][PosW-1:0] level;
    logic [SpeedW-1:0]             speed_thr;
    logic [TickW-1:0]              cutoff_ticks;
  } gss_cfg_t;

endpackage

FILE: hdl/gss_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file holding gear levels, speed threshold and cutoff time
module gss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gss_pkg::AddrW-1:0]     paddr,
  input  logic [gss_pkg::DataW-1:0]     pwdata,
  output logic [gss_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  output gss_pkg::gss_cfg_t             cfg
);
  import gss_pkg::*;

  gss_cfg_t cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NumGears; g++) begin
        cfg_r.level[g] <= LEVEL_RST[g];
      end
      cfg_r.speed_thr    <= SPEED_THR_RST;
      cfg_r.cutoff_ticks <= CUTOFF_TCK_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEVEL_0:     cfg_r.level[0] <= pwdata[PosW-1:0];
        REG_LEVEL_1:     cfg_r.level[1] <= pwdata[PosW-1:0];
        REG_LEVEL_2:     cfg_r.level[2] <= pwdata[PosW-1:0];
        REG_LEVEL_3:     cfg_r.level[3] <= pwdata[PosW-1:0];
        REG_LEVEL_4:     cfg_r.level[4] <= pwdata[PosW-1:0];
        REG_LEVEL_5:     cfg_r.level[5] <= pwdata[PosW-1:0];
        REG_SPEED_THR:   cfg_r.speed_thr <= pwdata[SpeedW-1:0];
        REG_CUTOFF_TCKS: cfg_r.cutoff_ticks <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LEVEL_0:     prdata[PosW-1:0] = cfg_r.level[0];
      REG_LEVEL_1:     prdata[PosW-1:0] = cfg_r.level[1];
      REG_LEVEL_2:     prdata[PosW-1:0] = cfg_r.level[2];
      REG_LEVEL_3:     prdata[PosW-1:0] = cfg_r.level[3];
      REG_LEVEL_4:     prdata[PosW-1:0] = cfg_r.level[4];
      REG_LEVEL_5:     prdata[PosW-1:0] = cfg_r.level[5];
      REG_SPEED_THR:   prdata[SpeedW-1:0] = cfg_r.speed_thr;
      REG_CUTOFF_TCKS: prdata[TickW-1:0] = cfg_r.cutoff_ticks;
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hdl/gss_gear_est.sv
`timescale 1ns / 1ps
// nearest configured gear level search, later index wins a tie
module gss_gear_est (
  input  logic [gss_pkg::PosW-1:0]                   pos,
  input  logic [gss_pkg::NumGears-1:0][gss_pkg::PosW-1:0] level,
  output logic [gss_pkg::GearW-1:0]                  gear
);
  import gss_pkg::*;

  logic [NumGears-1:0][PosW-1:0] lvl_gap;
  logic [PosW-1:0]               best;

  // absolute distance to each level
  always_comb begin
    for (int g = 0; g < NumGears; g++) begin
      lvl_gap[g] = (level[g] >= pos) ? (level[g] - pos) : (pos - level[g]);
    end
  end

  // running minimum, less-or-equal so the higher index takes ties
  always_comb begin
    best = MAX_DIST;
    gear = '0;
    for (int g = 0; g < NumGears; g++) begin
      if (lvl_gap[g] <= best) begin
        best = lvl_gap[g];
        gear = GearW'(g);
      end
    end
  end

endmodule

FILE: hdl/gear_shift_sequencer_unit.sv
`timescale 1ns / 1ps
// top level of the gear shift sequencer: input stage, sequencer, result stage
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | position, speed, up/down request, clutch
//  out_    | output    | out_valid/out_ready | cutoff, valves, gear estimate, clutch, busy
//  apb     | input     | psel/penable/pready | registers at byte address 4*index
//
//  one tick per cycle while the result side is not stalled: a transfer is
//  registered in the input stage, then the phase update and the nearest level
//  search run in one pass from there into the result register
//  the input stage refills whenever it is empty or the result register is
//  empty or taken; a waiting result blocks input only once the input stage
//  also holds a tick
//  rst_n is synchronous; it clears the phase, counter and valid flags and
//  loads the register reset values

module gear_shift_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gss_pkg::PosW-1:0]       in_position_sample,
  input  logic [gss_pkg::SpeedW-1:0]     in_engine_speed,
  input  logic                           in_up_request,
  input  logic                           in_down_request,
  input  logic [gss_pkg::ClutchW-1:0]    in_clutch_request,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_cutoff_drive,
  output logic                           out_upshift_valve,
  output logic                           out_downshift_valve,
  output logic [gss_pkg::GearW-1:0]      out_gear_estimate,
  output logic [gss_pkg::ClutchW-1:0]    out_clutch_level,
  output logic                           out_busy_res,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gss_pkg::AddrW-1:0]      paddr,
  input  logic [gss_pkg::DataW-1:0]      pwdata,
  output logic [gss_pkg::DataW-1:0]      prdata,
  output logic                           pready
);
  import gss_pkg::*;

  gss_cfg_t cfg;

  // input stage
  logic                 s1_valid_r;
  logic [PosW-1:0]      s1_pos_r;
  logic [SpeedW-1:0]    s1_speed_r;
  logic                 s1_up_r;
  logic                 s1_down_r;
  logic [ClutchW-1:0]   s1_clutch_r;

  // sequencer state
  phase_t               phase_r, phase_nxt;
  logic                 down_r, down_nxt;
  logic [TickW-1:0]     tick_r, tick_nxt;
  logic [TickW-1:0]     tick_dec;

  // result stage
  logic                 out_valid_r;
  logic                 cut_r, upv_r, dnv_r, busy_r;
  logic [GearW-1:0]     gear_r;
  logic [ClutchW-1:0]   clutch_r;

  logic                 out_free;
  logic                 s1_adv;
  logic [GearW-1:0]     gear_est;

  gss_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gss_gear_est u_gear (
    .pos   (s1_pos_r),
    .level (cfg.level),
    .gear  (gear_est)
  );

  // flow control
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // phase update for the tick in the input stage
  assign tick_dec = tick_r - 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    down_nxt  = down_r;
    tick_nxt  = tick_r;
    unique case (phase_r)
      PH_CUT: begin
        if (tick_dec == '0) begin
          phase_nxt = PH_HOLD;
          tick_nxt  = HOLD_TICKS;
        end else begin
          tick_nxt = tick_dec;
        end
      end
      PH_HOLD: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // idle, also any stray code
        phase_nxt = PH_IDLE;
        if (s1_up_r || s1_down_r) begin
          down_nxt = !s1_up_r;
          if ((s1_speed_r > cfg.speed_thr) && (cfg.cutoff_ticks != '0)) begin
            phase_nxt = PH_CUT;
            tick_nxt  = cfg.cutoff_ticks;
          end else begin
            phase_nxt = PH_HOLD;
            tick_nxt  = HOLD_TICKS;
          end
        end
      end
    endcase
  end

  // input stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pos_r    <= in_position_sample;
      s1_speed_r  <= in_engine_speed;
      s1_up_r     <= in_up_request;
      s1_down_r   <= in_down_request;
      s1_clutch_r <= in_clutch_request;
    end
  end

  // sequencer state advances once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      down_r  <= 1'b0;
      tick_r  <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      down_r  <= down_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cut_r    <= (phase_nxt == PH_CUT);
      upv_r    <= (phase_nxt == PH_HOLD) && !down_nxt;
      dnv_r    <= (phase_nxt == PH_HOLD) && down_nxt;
      busy_r   <= (phase_nxt != PH_IDLE);
      gear_r   <= gear_est;
      clutch_r <= s1_clutch_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cutoff_drive    = cut_r;
  assign out_upshift_valve   = upv_r;
  assign out_downshift_valve = dnv_r;
  assign out_gear_estimate   = gear_r;
  assign out_clutch_level    = clutch_r;
  assign out_busy_res        = busy_r;

  // a running phase always has ticks left
  a_tick_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CUT || phase_r == PH_HOLD) |-> (tick_r != '0))
    else $error("active phase with zero tick count");

  // cutoff and a valve are never driven together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(cut_r && (upv_r || dnv_r)) && !(upv_r && dnv_r))
    else $error("cutoff and valve driven together");

  // busy flag matches the drives
  a_busy_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (busy_r == (cut_r || upv_r || dnv_r)))
    else $error("busy flag disagrees with drives");

  // gear estimate stays in range
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (gear_r < GearW'(NumGears)))
    else $error("gear estimate out of range");

  // a held tick in the input stage is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_clutch_r)))
    else $error("input stage lost a stalled tick");

endmodule

FILE: tb/tb_gear_shift_sequencer_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the gear shift sequencer: directed table, then random ticks
module tb_gear_shift_sequencer_unit;
  import gss_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RAND_PER_SETTING = 27;
  localparam int NUM_SETTINGS     = 4;
  localparam int DIR_ROWS         = 21;
  localparam logic [TickW-1:0] HOLD_LEN = 16'd100;

  // one tick of sensor and request input
  typedef struct packed {
    logic [PosW-1:0]    pos;
    logic [SpeedW-1:0]  speed;
    logic               up;
    logic               down;
    logic [ClutchW-1:0] clutch;
  } tick_in_t;

  // drive state reported for one tick
  typedef struct packed {
    logic               cutoff;
    logic               up_valve;
    logic               down_valve;
    logic [GearW-1:0]   gear;
    logic [ClutchW-1:0] clutch;
    logic               busy;
  } drive_t;

  // directed row: optional register write, then the tick sent reps times
  typedef struct {
    logic        wr;
    reg_idx_t    wr_idx;
    logic [31:0] wr_val;
    int          reps;
    tick_in_t    t;
    logic        typed;
    drive_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [PosW-1:0] in_position_sample;
  logic [SpeedW-1:0] in_engine_speed;
  logic in_up_request;
  logic in_down_request;
  logic [ClutchW-1:0] in_clutch_request;
  logic out_valid;
  logic out_ready;
  logic out_cutoff_drive;
  logic out_upshift_valve;
  logic out_downshift_valve;
  logic [GearW-1:0] out_gear_estimate;
  logic [ClutchW-1:0] out_clutch_level;
  logic out_busy_res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  // sequencer prediction state and register copy
  phase_t            seq_phase;
  logic              seq_down;
  logic [TickW-1:0]  seq_ticks;
  logic [PosW-1:0]   gear_lvl [NumGears];
  logic [SpeedW-1:0] speed_thr;
  logic [TickW-1:0]  cutoff_len;

  drive_t exp_drives[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     cycles = 0;
  int     idle_odds = 0;

  // directed ticks, reset configuration unless a row writes a register
  row_t dir_rows [DIR_ROWS] = '{
    // exact level of gear 0
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd3260, 16'd0, 1'b0, 1'b0, 12'h000},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0}},
    // lowest position, top speed, top clutch
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd0, 16'hffff, 1'b0, 1'b0, 12'hfff},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd2, 12'hfff, 1'b0}},
    // highest position
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd4095, 16'h5555, 1'b0, 1'b0, 12'haaa},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd1, 12'haaa, 1'b0}},
    // tie between gears 4 and 5, higher index wins
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd1910, 16'haaaa, 1'b0, 1'b0, 12'h555},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd5, 12'h555, 1'b0}},
    // tie between gears 0 and 5
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd2755, 16'd0, 1'b0, 1'b0, 12'h001},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd5, 12'h001, 1'b0}},
    // tie between gears 0 and 1
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd3440, 16'd0, 1'b0, 1'b0, 12'h800},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd1, 12'h800, 1'b0}},
    // upshift at speed equal to threshold: no cutoff
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd875, 16'd11000, 1'b1, 1'b0, 12'h123},
      1'b1, '{1'b0, 1'b1, 1'b0, 3'd3, 12'h123, 1'b1}},
    // down requests while busy are ignored
    '{1'b0, REG_LEVEL_0, 32'd0, 99, '{12'h9c4, 16'hffff, 1'b0, 1'b1, 12'hfff},
      1'b0, '0},
    // request on the tick where the hold ends is ignored
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd200, 16'hffff, 1'b1, 1'b0, 12'h000},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd2, 12'h000, 1'b0}},
    // both requests above threshold: cutoff first, up wins
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd1570, 16'd11001, 1'b1, 1'b1, 12'h800},
      1'b1, '{1'b1, 1'b0, 1'b0, 3'd4, 12'h800, 1'b1}},
    '{1'b0, REG_LEVEL_0, 32'd0, 29, '{12'h7ff, 16'd0, 1'b0, 1'b0, 12'h7ff},
      1'b0, '0},
    '{1'b0, REG_LEVEL_0, 32'd0, 100, '{12'h3c0, 16'hffff, 1'b0, 1'b1, 12'h3c0},
      1'b0, '0},
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'h3c0, 16'd0, 1'b0, 1'b1, 12'h3c1},
      1'b0, '0},
    // downshift below threshold
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'd2250, 16'd0, 1'b0, 1'b1, 12'h0f0},
      1'b1, '{1'b0, 1'b0, 1'b1, 3'd5, 12'h0f0, 1'b1}},
    '{1'b0, REG_LEVEL_0, 32'd0, 99, '{12'h100, 16'h8000, 1'b0, 1'b0, 12'h0f0},
      1'b0, '0},
    '{1'b0, REG_LEVEL_0, 32'd0, 1, '{12'h100, 16'h8000, 1'b0, 1'b0, 12'h0f1},
      1'b0, '0},
    // zero cutoff time above threshold goes straight to the valve
    '{1'b1, REG_CUTOFF_TCKS, 32'd0, 1, '{12'd3620, 16'hffff, 1'b1, 1'b0, 12'h00f},
      1'b1, '{1'b0, 1'b1, 1'b0, 3'd1, 12'h00f, 1'b1}},
    '{1'b0, REG_LEVEL_0, 32'd0, 100, '{12'h555, 16'hffff, 1'b1, 1'b0, 12'h00f},
      1'b0, '0},
    '{1'b1, REG_SPEED_THR, 32'd0, 1, '{12'd0, 16'd0, 1'b0, 1'b0, 12'hf00},
      1'b1, '{1'b0, 1'b0, 1'b0, 3'd2, 12'hf00, 1'b0}},
    // single tick of cutoff
    '{1'b1, REG_CUTOFF_TCKS, 32'd1, 1, '{12'd4095, 16'd1, 1'b0, 1'b1, 12'h0aa},
      1'b1, '{1'b1, 1'b0, 1'b0, 3'd1, 12'h0aa, 1'b1}},
    '{1'b0, REG_LEVEL_0, 32'd0, 101, '{12'haaa, 16'd2, 1'b0, 1'b0, 12'h0ab},
      1'b0, '0}
  };

  gear_shift_sequencer_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_position_sample  (in_position_sample),
    .in_engine_speed     (in_engine_speed),
    .in_up_request       (in_up_request),
    .in_down_request     (in_down_request),
    .in_clutch_request   (in_clutch_request),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cutoff_drive    (out_cutoff_drive),
    .out_upshift_valve   (out_upshift_valve),
    .out_downshift_valve (out_downshift_valve),
    .out_gear_estimate   (out_gear_estimate),
    .out_clutch_level    (out_clutch_level),
    .out_busy_res        (out_busy_res),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // index of the nearest level, later index wins a tie
  function automatic logic [GearW-1:0] nearest_gear(input logic [PosW-1:0] pos);
    logic [PosW-1:0]  best;
    logic [PosW-1:0]  gap;
    logic [GearW-1:0] idx;
    best = 12'd4095;
    idx  = '0;
    for (int g = 0; g < NumGears; g++) begin
      gap = (gear_lvl[g] >= pos) ? gear_lvl[g] - pos : pos - gear_lvl[g];
      if (gap <= best) begin
        best = gap;
        idx  = GearW'(g);
      end
    end
    return idx;
  endfunction

  // advance the shift sequence by one tick and return its drives
  function automatic drive_t shift_tick(input tick_in_t t);
    drive_t d;
    case (seq_phase)
      PH_CUT: begin
        seq_ticks = seq_ticks - 16'd1;
        if (seq_ticks == '0) begin
          seq_phase = PH_HOLD;
          seq_ticks = HOLD_LEN;
        end
      end
      PH_HOLD: begin
        seq_ticks = seq_ticks - 16'd1;
        if (seq_ticks == '0) seq_phase = PH_IDLE;
      end
      default: begin
        seq_phase = PH_IDLE;
        if (t.up || t.down) begin
          seq_down = !t.up;
          if (t.speed > speed_thr && cutoff_len != '0) begin
            seq_phase = PH_CUT;
            seq_ticks = cutoff_len;
          end else begin
            seq_phase = PH_HOLD;
            seq_ticks = HOLD_LEN;
          end
        end
      end
    endcase
    d.cutoff     = (seq_phase == PH_CUT);
    d.up_valve   = (seq_phase == PH_HOLD) && !seq_down;
    d.down_valve = (seq_phase == PH_HOLD) && seq_down;
    d.gear       = nearest_gear(t.pos);
    d.clutch     = t.clutch;
    d.busy       = (seq_phase != PH_IDLE);
    return d;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               field, results_seen, got, want);
  endtask

  // one tick transfer, entered and left at a falling edge
  task automatic send_tick(input tick_in_t t, input logic typed, input drive_t typed_want);
    drive_t pred;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_position_sample <= t.pos;
    in_engine_speed    <= t.speed;
    in_up_request      <= t.up;
    in_down_request    <= t.down;
    in_clutch_request  <= t.clutch;
    do @(posedge clk); while (!in_ready);
    pred = shift_tick(t);
    exp_drives.push_back(typed ? typed_want : pred);
    @(negedge clk);
  endtask

  // stop sending and wait until every pending result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup then access, register taken at the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SPEED_THR:   speed_thr  = val[SpeedW-1:0];
      REG_CUTOFF_TCKS: cutoff_len = val[TickW-1:0];
      default:         gear_lvl[idx] = val[PosW-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // result side stalls in random bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    drive_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (exp_drives.size() == 0) begin
        report_mismatch("unexpected result", 16'd1, 16'd0);
      end else begin
        want = exp_drives.pop_front();
        if (out_cutoff_drive !== want.cutoff)
          report_mismatch("cutoff_drive", 16'(out_cutoff_drive), 16'(want.cutoff));
        if (out_upshift_valve !== want.up_valve)
          report_mismatch("upshift_valve", 16'(out_upshift_valve), 16'(want.up_valve));
        if (out_downshift_valve !== want.down_valve)
          report_mismatch("downshift_valve", 16'(out_downshift_valve),
                          16'(want.down_valve));
        if (out_gear_estimate !== want.gear)
          report_mismatch("gear_estimate", 16'(out_gear_estimate), 16'(want.gear));
        if (out_clutch_level !== want.clutch)
          report_mismatch("clutch_level", 16'(out_clutch_level), 16'(want.clutch));
        if (out_busy_res !== want.busy)
          report_mismatch("busy_res", 16'(out_busy_res), 16'(want.busy));
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    tick_in_t    t;
    logic [31:0] vals [8];
    int          a;
    int          b;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_position_sample = '0;
    in_engine_speed    = '0;
    in_up_request      = 1'b0;
    in_down_request    = 1'b0;
    in_clutch_request  = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    gear_lvl   = '{12'd3260, 12'd3620, 12'd200, 12'd875, 12'd1570, 12'd2250};
    speed_thr  = 16'd11000;
    cutoff_len = 16'd30;
    seq_phase  = PH_IDLE;
    seq_down   = 1'b0;
    seq_ticks  = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    idle_odds = 3;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].wr) begin
        drain_results();
        write_reg(dir_rows[k].wr_idx, dir_rows[k].wr_val);
      end
      repeat (dir_rows[k].reps) send_tick(dir_rows[k].t, dir_rows[k].typed, dir_rows[k].want);
    end

    // random ticks under several register settings, last one without idling
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain_results();
      case (s)
        0: begin
          for (int g = 0; g < NumGears; g++) vals[g] = $urandom_range(0, 4095);
          vals[REG_SPEED_THR]   = $urandom_range(0, 65535);
          vals[REG_CUTOFF_TCKS] = $urandom_range(1, 6);
          idle_odds = 3;
        end
        1: begin
          vals[0] = 32'd0;
          vals[1] = 32'd4095;
          vals[2] = 32'd0;
          vals[3] = 32'd4095;
          vals[4] = 32'd2048;
          vals[5] = 32'd2047;
          vals[REG_SPEED_THR]   = 32'd0;
          vals[REG_CUTOFF_TCKS] = 32'd0;
          idle_odds = 5;
        end
        2: begin
          for (int g = 0; g < NumGears; g++) vals[g] = 32'd4095;
          vals[REG_SPEED_THR]   = 32'd65535;
          vals[REG_CUTOFF_TCKS] = 32'd65535;
          idle_odds = 2;
        end
        default: begin
          // coarse grid so that levels repeat and ties are common
          for (int g = 0; g < NumGears; g++) vals[g] = $urandom_range(0, 7) * 585;
          vals[REG_SPEED_THR]   = $urandom_range(0, 65535);
          vals[REG_CUTOFF_TCKS] = $urandom_range(1, 40);
          idle_odds = 0;
        end
      endcase
      for (int r = 0; r < 8; r++) write_reg(reg_idx_t'(r), vals[r]);

      repeat (RAND_PER_SETTING) begin
        // position on a level, halfway between two levels, or anywhere
        case ($urandom_range(0, 2))
          0: t.pos = gear_lvl[$urandom_range(0, NumGears - 1)];
          1: begin
            a = $urandom_range(0, NumGears - 1);
            b = $urandom_range(0, NumGears - 1);
            t.pos = PosW'(({1'b0, gear_lvl[a]} + {1'b0, gear_lvl[b]}) >> 1);
          end
          default: t.pos = PosW'($urandom);
        endcase
        // speed around the threshold or anywhere
        if ($urandom_range(0, 3) == 0)
          t.speed = speed_thr + SpeedW'($urandom_range(0, 2)) - 16'd1;
        else
          t.speed = SpeedW'($urandom);
        t.up     = ($urandom_range(0, 3) == 0);
        t.down   = ($urandom_range(0, 3) == 0);
        t.clutch = ClutchW'($urandom);
        send_tick(t, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0 && exp_drives.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
